[hdl/r2fft_pkg.sv]
// Shared types and constants of the radix-2 complex FFT block.
`default_nettype none

package r2fft_pkg;

  localparam int IDX_W   = 10;
  localparam int BIN_W   = 27;
  localparam int OP_W    = 2;
  localparam int CFG_W   = 4;
  localparam int TW_W    = 18;
  localparam int TW_FRAC = 16;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic CFG_SIZE_LOG2 = 1'b0;
  localparam logic CFG_INVERSE   = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    WD_SAMPLE,
    WD_SUM,
    WD_DIFF,
    WD_E,
    WD_O,
    WD_SCALE
  } wsel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SW_RD_I,
    ST_SW_RD_J,
    ST_SW_CAP,
    ST_SW_WR_I,
    ST_SW_WR_J,
    ST_BF_RD_E,
    ST_BF_RD_O,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WR_E,
    ST_BF_WR_O,
    ST_SC_RD,
    ST_SC_WR
  } state_t;

  typedef struct packed {
    logic  rd_en;
    logic  wr_en;
    wsel_t wsel;
    logic  tw_en;
    logic  cap_e;
    logic  cap_o;
    logic  mul_en;
    logic  sum_en;
    logic  out_load;
    logic  pend_load;
    logic  inv;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } stat_t;

endpackage

`default_nettype wire

[hdl/r2fft_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module r2fft_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/r2fft_ctrl.sv]
// Controller: configuration registers, handshakes and the run sequencer.
`default_nettype none

module r2fft_ctrl #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [r2fft_pkg::OP_W-1:0]             in_op,
  input  wire logic [$clog2(MAX_POINTS)-1:0]          in_addr,
  input  wire logic                                   cfg_valid,
  input  wire logic                                   cfg_index,
  input  wire logic [r2fft_pkg::CFG_W-1:0]            cfg_data,
  input  wire logic                                   out_ready,
  output logic                                        out_valid,
  output r2fft_pkg::cmd_t                             cmd,
  output logic      [$clog2(MAX_POINTS)-1:0]          rd_addr,
  output logic      [$clog2(MAX_POINTS)-1:0]          wr_addr,
  output logic      [$clog2(MAX_POINTS)-1:0]          tw_m,
  output logic      [$clog2($clog2(MAX_POINTS)+1)-1:0] lg,
  output r2fft_pkg::stat_t                            status
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int LW = $clog2(AW + 1);

  function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] x);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) begin
      r[b] = x[AW-1-b];
    end
    return r;
  endfunction

  r2fft_pkg::state_t state_r, state_nxt;
  logic [r2fft_pkg::CFG_W-1:0] size_r, size_nxt;
  logic inv_r, inv_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] st_r, st_nxt;
  logic pend_r, pend_nxt;
  logic oval_r, oval_nxt;

  logic out_free;
  logic in_fire;
  logic [AW-1:0] last_n, last_h, j_addr, hmask, e_addr, o_addr;
  logic swap_here;

  always_comb begin
    if (size_r == '0) begin
      lg = LW'(1);
    end else if (32'(size_r) > AW) begin
      lg = LW'(AW);
    end else begin
      lg = LW'(size_r);
    end
  end

  assign last_n    = ~({AW{1'b1}} << lg);
  assign last_h    = last_n >> 1;
  assign j_addr    = bit_rev(cnt_r) >> (AW - 32'(lg));
  assign swap_here = cnt_r < j_addr;
  assign hmask     = ~({AW{1'b1}} << st_r);
  assign e_addr    = ((cnt_r >> st_r) << (st_r + LW'(1))) | (cnt_r & hmask);
  assign o_addr    = e_addr | (AW'(1) << st_r);
  assign tw_m      = (cnt_r & hmask) << ((AW - 1) - 32'(st_r));

  assign out_free  = !oval_r || out_ready;
  assign in_ready  = (state_r == r2fft_pkg::ST_IDLE) && (!pend_r || out_free);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = oval_r;
  assign status.busy = (state_r != r2fft_pkg::ST_IDLE);

  always_comb begin
    size_nxt = size_r;
    inv_nxt  = inv_r;
    if (cfg_valid) begin
      if (cfg_index == r2fft_pkg::CFG_SIZE_LOG2) begin
        size_nxt = cfg_data;
      end else begin
        inv_nxt = cfg_data[0];
      end
    end
    pend_nxt = (in_fire && in_op == r2fft_pkg::OP_READ) || (pend_r && !out_free);
    oval_nxt = (pend_r && out_free) || (oval_r && !out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    st_nxt    = st_r;
    case (state_r)
      r2fft_pkg::ST_IDLE: begin
        if (in_fire && in_op == r2fft_pkg::OP_RUN) begin
          state_nxt = r2fft_pkg::ST_SW_RD_I;
          cnt_nxt   = '0;
        end
      end
      r2fft_pkg::ST_SW_RD_I: begin
        if (swap_here) begin
          state_nxt = r2fft_pkg::ST_SW_RD_J;
        end else if (cnt_r == last_n) begin
          state_nxt = r2fft_pkg::ST_BF_RD_E;
          cnt_nxt   = '0;
          st_nxt    = '0;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      r2fft_pkg::ST_SW_RD_J: state_nxt = r2fft_pkg::ST_SW_CAP;
      r2fft_pkg::ST_SW_CAP:  state_nxt = r2fft_pkg::ST_SW_WR_I;
      r2fft_pkg::ST_SW_WR_I: state_nxt = r2fft_pkg::ST_SW_WR_J;
      r2fft_pkg::ST_SW_WR_J: begin
        if (cnt_r == last_n) begin
          state_nxt = r2fft_pkg::ST_BF_RD_E;
          cnt_nxt   = '0;
          st_nxt    = '0;
        end else begin
          state_nxt = r2fft_pkg::ST_SW_RD_I;
          cnt_nxt   = cnt_r + AW'(1);
        end
      end
      r2fft_pkg::ST_BF_RD_E: state_nxt = r2fft_pkg::ST_BF_RD_O;
      r2fft_pkg::ST_BF_RD_O: state_nxt = r2fft_pkg::ST_BF_MUL;
      r2fft_pkg::ST_BF_MUL:  state_nxt = r2fft_pkg::ST_BF_SUM;
      r2fft_pkg::ST_BF_SUM:  state_nxt = r2fft_pkg::ST_BF_WR_E;
      r2fft_pkg::ST_BF_WR_E: state_nxt = r2fft_pkg::ST_BF_WR_O;
      r2fft_pkg::ST_BF_WR_O: begin
        cnt_nxt = cnt_r + AW'(1);
        state_nxt = r2fft_pkg::ST_BF_RD_E;
        if (cnt_r == last_h) begin
          cnt_nxt = '0;
          if (st_r == lg - LW'(1)) begin
            state_nxt = inv_r ? r2fft_pkg::ST_SC_RD : r2fft_pkg::ST_IDLE;
          end else begin
            st_nxt = st_r + LW'(1);
          end
        end
      end
      r2fft_pkg::ST_SC_RD: state_nxt = r2fft_pkg::ST_SC_WR;
      r2fft_pkg::ST_SC_WR: begin
        if (cnt_r == last_n) begin
          state_nxt = r2fft_pkg::ST_IDLE;
        end else begin
          state_nxt = r2fft_pkg::ST_SC_RD;
          cnt_nxt   = cnt_r + AW'(1);
        end
      end
      default: state_nxt = r2fft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.wsel     = r2fft_pkg::WD_SAMPLE;
    cmd.inv      = inv_r;
    cmd.out_load = pend_r && out_free;
    rd_addr      = cnt_r;
    wr_addr      = cnt_r;
    case (state_r)
      r2fft_pkg::ST_IDLE: begin
        rd_addr = in_addr;
        wr_addr = in_addr;
        if (in_fire && in_op == r2fft_pkg::OP_WRITE) begin
          cmd.wr_en = 1'b1;
        end
        if (in_fire && in_op == r2fft_pkg::OP_READ) begin
          cmd.rd_en     = 1'b1;
          cmd.pend_load = 1'b1;
        end
      end
      r2fft_pkg::ST_SW_RD_I: cmd.rd_en = swap_here;
      r2fft_pkg::ST_SW_RD_J: begin
        cmd.rd_en = 1'b1;
        rd_addr   = j_addr;
        cmd.cap_e = 1'b1;
      end
      r2fft_pkg::ST_SW_CAP: cmd.cap_o = 1'b1;
      r2fft_pkg::ST_SW_WR_I: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = r2fft_pkg::WD_O;
      end
      r2fft_pkg::ST_SW_WR_J: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = r2fft_pkg::WD_E;
        wr_addr   = j_addr;
      end
      r2fft_pkg::ST_BF_RD_E: begin
        cmd.rd_en = 1'b1;
        cmd.tw_en = 1'b1;
        rd_addr   = e_addr;
      end
      r2fft_pkg::ST_BF_RD_O: begin
        cmd.rd_en = 1'b1;
        cmd.cap_e = 1'b1;
        rd_addr   = o_addr;
      end
      r2fft_pkg::ST_BF_MUL: cmd.mul_en = 1'b1;
      r2fft_pkg::ST_BF_SUM: cmd.sum_en = 1'b1;
      r2fft_pkg::ST_BF_WR_E: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = r2fft_pkg::WD_SUM;
        wr_addr   = e_addr;
      end
      r2fft_pkg::ST_BF_WR_O: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = r2fft_pkg::WD_DIFF;
        wr_addr   = o_addr;
      end
      r2fft_pkg::ST_SC_RD: cmd.rd_en = 1'b1;
      r2fft_pkg::ST_SC_WR: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = r2fft_pkg::WD_SCALE;
      end
      default: cmd.inv = inv_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= r2fft_pkg::ST_IDLE;
      size_r  <= r2fft_pkg::CFG_W'(10);
      inv_r   <= 1'b0;
      cnt_r   <= '0;
      st_r    <= '0;
      pend_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      inv_r   <= inv_nxt;
      cnt_r   <= cnt_nxt;
      st_r    <= st_nxt;
      pend_r  <= pend_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/r2fft_dpath.sv]
// Datapath: point buffer, twiddle ROM, butterfly arithmetic and output word.
`default_nettype none

module r2fft_dpath #(
  parameter int MAX_POINTS  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                    clk,
  input  r2fft_pkg::cmd_t                              cmd,
  input  wire logic [$clog2(MAX_POINTS)-1:0]           rd_addr,
  input  wire logic [$clog2(MAX_POINTS)-1:0]           wr_addr,
  input  wire logic [$clog2(MAX_POINTS)-1:0]           tw_m,
  input  wire logic [$clog2($clog2(MAX_POINTS)+1)-1:0] lg,
  input  wire logic [r2fft_pkg::IDX_W-1:0]             in_idx,
  input  wire logic signed [SAMPLE_BITS-1:0]           in_re,
  input  wire logic signed [SAMPLE_BITS-1:0]           in_im,
  output logic      [r2fft_pkg::IDX_W-1:0]             out_idx,
  output logic signed [r2fft_pkg::BIN_W-1:0]           out_re,
  output logic signed [r2fft_pkg::BIN_W-1:0]           out_im
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int LW   = $clog2(AW + 1);
  localparam int BW   = r2fft_pkg::BIN_W;
  localparam int TWW  = r2fft_pkg::TW_W;
  localparam int PW   = BW + TWW;
  localparam int TVW  = PW + 1 - r2fft_pkg::TW_FRAC;
  localparam int QTR  = MAX_POINTS / 4;
  localparam int HALF = MAX_POINTS / 2;

  typedef logic [TWW-2:0] rom_arr_t [0:QTR];

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] cos_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic signed [63:0] sum;
    logic [63:0] d;
    x2  = (x * x + (64'd1 << 29)) >> 30;
    t   = 64'd1 << 30;
    sum = 64'sd1 <<< 30;
    for (int n = 1; n <= 12; n++) begin
      d = 64'((2 * n - 1) * (2 * n));
      t = udiv64((t * x2) >> 30, d);
      if ((n & 1) == 1) begin
        sum = sum - $signed(t);
      end else begin
        sum = sum + $signed(t);
      end
    end
    return sum;
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t r;
    logic [63:0] x;
    logic signed [63:0] v;
    for (int k = 0; k <= QTR; k++) begin
      x = (64'(k) * 64'd2 * r2fft_pkg::PI_Q30 + 64'(HALF)) >> AW;
      v = cos_q30(x);
      if (v < 0) begin
        v = 0;
      end
      if (v > (64'sd1 <<< 30)) begin
        v = 64'sd1 <<< 30;
      end
      r[k] = (TWW-1)'((64'(v) + (64'd1 << 13)) >> 14);
    end
    return r;
  endfunction

  localparam rom_arr_t TW_ROM = build_rom();

  function automatic logic signed [BW-1:0] sat_bin(input logic signed [33:0] v);
    if (v > 34'sd67108863) begin
      return BW'(67108863);
    end else if (v < -34'sd67108864) begin
      return BW'(-67108864);
    end
    return BW'(v);
  endfunction

  logic [2*BW-1:0] rdata, wdata;
  logic signed [BW-1:0] d_re, d_im;

  logic [2*BW-1:0] e_r, e_nxt, o_r, o_nxt;
  logic signed [TWW-1:0] c_r, c_nxt, s_r, s_nxt;
  logic signed [PW-1:0] p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  logic signed [TVW-1:0] t_re_r, t_re_nxt, t_im_r, t_im_nxt;
  logic [r2fft_pkg::IDX_W-1:0] pidx_r, pidx_nxt, oidx_r, oidx_nxt;
  logic signed [BW-1:0] ore_r, ore_nxt, oim_r, oim_nxt;

  logic [AW-1:0] ci, si;
  logic c_neg;
  logic signed [TWW-1:0] c_val, s_val;
  logic signed [BW-1:0] e_re, e_im, sc_re, sc_im;
  logic signed [PW:0] v_re, v_im;
  logic signed [BW:0] rnd_re, rnd_im, rbias;

  r2fft_ram #(
    .WIDTH (2 * BW),
    .DEPTH (MAX_POINTS)
  ) u_buf (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign d_re = rdata[BW-1:0];
  assign d_im = rdata[2*BW-1:BW];
  assign e_re = e_r[BW-1:0];
  assign e_im = e_r[2*BW-1:BW];

  always_comb begin
    c_neg = tw_m > AW'(QTR);
    ci    = c_neg ? AW'(HALF) - tw_m : tw_m;
    si    = c_neg ? tw_m - AW'(QTR) : AW'(QTR) - tw_m;
    c_val = $signed({1'b0, TW_ROM[ci[AW-2:0]]});
    s_val = $signed({1'b0, TW_ROM[si[AW-2:0]]});
    if (c_neg) begin
      c_val = -c_val;
    end
    if (!cmd.inv) begin
      s_val = -s_val;
    end
  end

  always_comb begin
    rbias  = (BW+1)'(1) <<< (lg - LW'(1));
    rnd_re = ((BW+1)'(d_re) + rbias) >>> lg;
    rnd_im = ((BW+1)'(d_im) + rbias) >>> lg;
    sc_re  = sat_bin(34'(rnd_re));
    sc_im  = sat_bin(34'(rnd_im));
    v_re   = (PW+1)'(p0_r) - (PW+1)'(p1_r);
    v_im   = (PW+1)'(p2_r) + (PW+1)'(p3_r);
  end

  always_comb begin
    case (cmd.wsel)
      r2fft_pkg::WD_SAMPLE: wdata = {sat_bin(34'(in_im)), sat_bin(34'(in_re))};
      r2fft_pkg::WD_SUM:    wdata = {sat_bin(34'(e_im) + 34'(t_im_r)),
                                     sat_bin(34'(e_re) + 34'(t_re_r))};
      r2fft_pkg::WD_DIFF:   wdata = {sat_bin(34'(e_im) - 34'(t_im_r)),
                                     sat_bin(34'(e_re) - 34'(t_re_r))};
      r2fft_pkg::WD_E:      wdata = e_r;
      r2fft_pkg::WD_O:      wdata = o_r;
      r2fft_pkg::WD_SCALE:  wdata = {sc_im, sc_re};
      default:              wdata = rdata;
    endcase
  end

  always_comb begin
    e_nxt    = cmd.cap_e ? rdata : e_r;
    o_nxt    = cmd.cap_o ? rdata : o_r;
    c_nxt    = cmd.tw_en ? c_val : c_r;
    s_nxt    = cmd.tw_en ? s_val : s_r;
    p0_nxt   = cmd.mul_en ? PW'(d_re) * PW'(c_r) : p0_r;
    p1_nxt   = cmd.mul_en ? PW'(d_im) * PW'(s_r) : p1_r;
    p2_nxt   = cmd.mul_en ? PW'(d_re) * PW'(s_r) : p2_r;
    p3_nxt   = cmd.mul_en ? PW'(d_im) * PW'(c_r) : p3_r;
    t_re_nxt = cmd.sum_en ? TVW'((v_re + (PW+1)'(32768)) >>> r2fft_pkg::TW_FRAC) : t_re_r;
    t_im_nxt = cmd.sum_en ? TVW'((v_im + (PW+1)'(32768)) >>> r2fft_pkg::TW_FRAC) : t_im_r;
    pidx_nxt = cmd.pend_load ? in_idx : pidx_r;
    oidx_nxt = cmd.out_load ? pidx_r : oidx_r;
    ore_nxt  = cmd.out_load ? d_re : ore_r;
    oim_nxt  = cmd.out_load ? d_im : oim_r;
  end

  always_ff @(posedge clk) begin
    e_r    <= e_nxt;
    o_r    <= o_nxt;
    c_r    <= c_nxt;
    s_r    <= s_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    p3_r   <= p3_nxt;
    t_re_r <= t_re_nxt;
    t_im_r <= t_im_nxt;
    pidx_r <= pidx_nxt;
    oidx_r <= oidx_nxt;
    ore_r  <= ore_nxt;
    oim_r  <= oim_nxt;
  end

  assign out_idx = oidx_r;
  assign out_re  = ore_r;
  assign out_im  = oim_r;

endmodule

`default_nettype wire

[hdl/radix2_complex_fft.sv]
// Top level of the in-place radix-2 decimation-in-time complex FFT.
// Write words stream at one per cycle while idle and no read result is stalled at the output.
// Read words stream at one per cycle unless the output stalls; read data and a pending flag
// are registered, then loaded into the output word, which raises out_tvalid. A run swaps
// bit-reversed pairs, does (N/2)*log2(N) butterflies and, in inverse mode, scales by 1/N.
// Reset clears control and sets size_log2 to 10 and forward mode; buffer contents stay undefined.
`default_nettype none

module radix2_complex_fft #(
  parameter int MAX_POINTS  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // point_index, sample_real, sample_imag; zero padded to bytes
  input  wire logic [((r2fft_pkg::IDX_W+2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // operation
  input  wire logic [r2fft_pkg::OP_W-1:0] in_tuser,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // bin_index, bin_real, bin_imag
  output logic      [r2fft_pkg::IDX_W+2*r2fft_pkg::BIN_W-1:0] out_tdata,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_index,
  input  wire logic [r2fft_pkg::CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int LW = $clog2(AW + 1);
  localparam int IW = r2fft_pkg::IDX_W;
  localparam int EW = (AW > IW) ? AW : IW;

  r2fft_pkg::cmd_t  cmd;
  r2fft_pkg::stat_t status;
  logic [AW-1:0] rd_addr, wr_addr, tw_m, in_addr;
  logic [LW-1:0] lg;
  logic [EW-1:0] idx_ext;
  logic [IW-1:0] out_idx;
  logic signed [r2fft_pkg::BIN_W-1:0] out_re, out_im;

  assign idx_ext   = EW'(in_tdata[IW-1:0]);
  assign in_addr   = idx_ext[AW-1:0];
  assign cfg_ready = !status.busy;
  assign out_tdata = {out_im, out_re, out_idx};

  r2fft_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_addr   (in_addr),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .tw_m      (tw_m),
    .lg        (lg),
    .status    (status)
  );

  r2fft_dpath #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk     (clk),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .tw_m    (tw_m),
    .lg      (lg),
    .in_idx  (IW'(in_addr)),
    .in_re   (in_tdata[IW +: SAMPLE_BITS]),
    .in_im   (in_tdata[IW+SAMPLE_BITS +: SAMPLE_BITS]),
    .out_idx (out_idx),
    .out_re  (out_re),
    .out_im  (out_im)
  );

  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == r2fft_pkg::OP_RUN) |=> status.busy)
    else $error("accepted run did not start the sequencer");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    status.busy |-> !in_tready)
    else $error("input accepted while a run is in progress");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

endmodule

`default_nettype wire
